// File: src/oahs_pkg.sv
// Shared types and constants for the open addressing hash set core.
// No dependencies; design files use scoped names into it, sim files import it.
package oahs_pkg;

	localparam int SLOTS_DEF     = 1024;
	localparam int KEY_BYTES_DEF = 4;

	localparam int KEY_W       = 32;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 3;
	localparam int SLOT_OUT_W  = 10;
	localparam int TOTAL_OUT_W = 11;

	localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

	// hash bits folded into the slot remainder per cycle (non power of two tables)
	localparam int MOD_BITS = 4;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;

	typedef enum logic [1:0] {
		MARK_EMPTY  = 2'd0,
		MARK_FILLED = 2'd1,
		MARK_TOMB   = 2'd2
	} mark_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED    = 3'd0,
		ST_PRESENT_INS = 3'd1,
		ST_REMOVED     = 3'd2,
		ST_NOT_FOUND   = 3'd3,
		ST_PRESENT     = 3'd4,
		ST_ABSENT      = 3'd5,
		ST_EMPTY_SET   = 3'd6,
		ST_FULL        = 3'd7
	} status_t;

	typedef struct packed {
		mark_t             mark;
		logic [KEY_W-1:0]  key;
	} entry_t;

	typedef enum logic [1:0] {
		HP_IDLE,
		HP_FNV,
		HP_MOD,
		HP_DONE
	} hash_phase_t;

	typedef enum logic [1:0] {
		CS_CLEAR,
		CS_IDLE,
		CS_HASH,
		CS_PROBE
	} ctrl_state_t;

endpackage

// File: src/oahs_if.sv
// Request and response channel interfaces (valid/ready handshake).
// Depends on oahs_pkg for field widths.
interface oahs_req_if;
	logic                              valid;
	logic                              ready;
	logic [oahs_pkg::FUNC_W-1:0]       func;
	logic [oahs_pkg::KEY_W-1:0]        key;

	modport source (output valid, func, key, input ready);
	modport sink   (input valid, func, key, output ready);
endinterface

interface oahs_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [oahs_pkg::STATUS_W-1:0]     status;
	logic [oahs_pkg::SLOT_OUT_W-1:0]   slot_index;
	logic [oahs_pkg::TOTAL_OUT_W-1:0]  element_total;

	modport source (output valid, status, slot_index, element_total, input ready);
	modport sink   (input valid, status, slot_index, element_total, output ready);
endinterface

// File: src/oahs_hash.sv
// Iterative FNV-1a hash, one key byte per cycle, then reduction to a home slot.
// Depends on oahs_pkg.
module oahs_hash #(
	parameter int SLOTS     = oahs_pkg::SLOTS_DEF,
	parameter int KEY_BYTES = oahs_pkg::KEY_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [oahs_pkg::KEY_W-1:0] key,
	output logic                       done,
	output logic [$clog2(SLOTS)-1:0]   home
);

	localparam int IDX_W   = $clog2(SLOTS);
	localparam bit POW2    = (SLOTS & (SLOTS - 1)) == 0;
	localparam int MOD_STP = oahs_pkg::MOD_BITS;
	localparam int MOD_CYC = oahs_pkg::KEY_W / MOD_STP;
	localparam int CNT_MAX = (KEY_BYTES > MOD_CYC) ? KEY_BYTES : MOD_CYC;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);

	oahs_pkg::hash_phase_t phase_q, phase_nx;

	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       h_q;
	logic [31:0]       ksh_q;
	logic [IDX_W-1:0]  r_q;
	logic [31:0]       h_mul;
	logic [IDX_W-1:0]  r_step;

	assign h_mul = (h_q ^ {24'd0, ksh_q[7:0]}) * oahs_pkg::FNV_PRIME;

	// r = (r * 2 + bit) mod SLOTS, MSB first; one compare-subtract per bit
	always_comb begin
		logic [IDX_W:0] t;
		logic [IDX_W-1:0] r;
		r = r_q;
		for (int j = 0; j < MOD_STP; j++) begin
			t = {r, h_q[31-j]};
			if (t >= (IDX_W+1)'(SLOTS))
				t = t - (IDX_W+1)'(SLOTS);
			r = t[IDX_W-1:0];
		end
		r_step = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= oahs_pkg::HP_IDLE;
		else
			phase_q <= phase_nx;
	end

	always_comb begin
		phase_nx = phase_q;
		done     = 1'b0;
		home     = POW2 ? h_q[IDX_W-1:0] : r_q;
		unique case (phase_q)
			oahs_pkg::HP_IDLE: begin
				if (start)
					phase_nx = oahs_pkg::HP_FNV;
			end
			oahs_pkg::HP_FNV: begin
				if (cnt_q == CNT_W'(1))
					phase_nx = POW2 ? oahs_pkg::HP_DONE : oahs_pkg::HP_MOD;
			end
			oahs_pkg::HP_MOD: begin
				if (cnt_q == CNT_W'(1))
					phase_nx = oahs_pkg::HP_DONE;
			end
			oahs_pkg::HP_DONE: begin
				done     = 1'b1;
				phase_nx = oahs_pkg::HP_IDLE;
			end
			default: phase_nx = oahs_pkg::HP_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			oahs_pkg::HP_IDLE: begin
				if (start) begin
					h_q   <= oahs_pkg::FNV_BASIS;
					ksh_q <= key;
					cnt_q <= CNT_W'(KEY_BYTES);
				end
			end
			oahs_pkg::HP_FNV: begin
				h_q   <= h_mul;
				ksh_q <= ksh_q >> 8;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					cnt_q <= CNT_W'(MOD_CYC);
					r_q   <= '0;
				end
			end
			oahs_pkg::HP_MOD: begin
				r_q   <= r_step;
				h_q   <= h_q << MOD_STP;
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// File: src/oahs_store.sv
// Slot memory: mark and key per slot, one write port, one registered read port.
// Depends on oahs_pkg for the entry type.
module oahs_store #(
	parameter int SLOTS = oahs_pkg::SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(SLOTS)-1:0] waddr,
	input  oahs_pkg::entry_t         wdata,
	input  logic [$clog2(SLOTS)-1:0] raddr,
	output oahs_pkg::entry_t         rdata
);

	oahs_pkg::entry_t mem [SLOTS];
	oahs_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/oahs_ctrl.sv
// Sequencer: clearing pass, request intake, linear probe over the slot memory,
// update and result register. Depends on oahs_pkg and the channel interfaces.
module oahs_ctrl #(
	parameter int SLOTS     = oahs_pkg::SLOTS_DEF,
	parameter int KEY_BYTES = oahs_pkg::KEY_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	oahs_req_if.sink                   req,
	oahs_rsp_if.source                 rsp,
	output logic                       hash_start,
	output logic [oahs_pkg::KEY_W-1:0] hash_key,
	input  logic                       hash_done,
	input  logic [$clog2(SLOTS)-1:0]   hash_home,
	output logic                       mem_we,
	output logic [$clog2(SLOTS)-1:0]   mem_waddr,
	output oahs_pkg::entry_t           mem_wdata,
	output logic [$clog2(SLOTS)-1:0]   mem_raddr,
	input  oahs_pkg::entry_t           mem_rdata
);

	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int SLOT_W  = oahs_pkg::SLOT_OUT_W;
	localparam int TOTAL_W = oahs_pkg::TOTAL_OUT_W;
	localparam logic [31:0] KEY_MASK = (KEY_BYTES >= 4) ? 32'hFFFF_FFFF :
		32'((64'd1 << (8 * KEY_BYTES)) - 64'd1);

	oahs_pkg::ctrl_state_t state_q, state_nx;

	logic [IDX_W-1:0]            clr_q;
	logic [oahs_pkg::FUNC_W-1:0] func_q;
	logic [oahs_pkg::KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]            idx_q;
	logic [CNT_W-1:0]            steps_q;
	logic                        tomb_seen_q;
	logic [IDX_W-1:0]            tomb_at_q;
	logic [CNT_W-1:0]            count_q;
	logic                        out_valid_q;
	oahs_pkg::status_t           status_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [TOTAL_W-1:0]          total_q;

	logic              accept;
	logic              clr_last;
	logic [IDX_W-1:0]  idx_nx;
	logic              is_empty, is_hit, is_tomb, last_slot, finish;
	logic              found, land_ok;
	logic [IDX_W-1:0]  where;
	logic              out_busy, commit;
	oahs_pkg::status_t res_status;
	logic [IDX_W-1:0]  res_slot;
	logic [CNT_W-1:0]  count_nx;
	logic              upd_en;
	oahs_pkg::mark_t   upd_mark;

	assign accept   = req.valid && req.ready;
	assign clr_last = clr_q == IDX_W'(SLOTS - 1);
	assign idx_nx   = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;

	assign hash_start = accept;
	assign hash_key   = req.key & KEY_MASK;

	// probe evaluation of the slot at idx_q (its data arrives this cycle)
	assign is_empty  = mem_rdata.mark == oahs_pkg::MARK_EMPTY;
	assign is_hit    = mem_rdata.mark == oahs_pkg::MARK_FILLED && mem_rdata.key == key_q;
	assign is_tomb   = !is_empty && mem_rdata.mark != oahs_pkg::MARK_FILLED;
	assign last_slot = steps_q == CNT_W'(SLOTS - 1);
	assign finish    = is_empty || is_hit || last_slot;
	assign found     = is_hit;
	assign land_ok   = is_empty || tomb_seen_q || is_tomb;
	assign where     = (is_hit || is_empty || !tomb_seen_q) ? idx_q : tomb_at_q;

	assign out_busy = out_valid_q && !rsp.ready;
	assign commit   = state_q == oahs_pkg::CS_PROBE && finish && !out_busy;

	always_comb begin
		res_status = oahs_pkg::ST_ABSENT;
		res_slot   = '0;
		count_nx   = count_q;
		upd_en     = 1'b0;
		upd_mark   = oahs_pkg::MARK_FILLED;
		priority if (func_q == oahs_pkg::FUNC_INSERT) begin
			if (found) begin
				res_status = oahs_pkg::ST_PRESENT_INS;
				res_slot   = where;
			end else if (land_ok) begin
				res_status = oahs_pkg::ST_INSERTED;
				res_slot   = where;
				count_nx   = count_q + 1'b1;
				upd_en     = 1'b1;
			end else begin
				res_status = oahs_pkg::ST_FULL;
			end
		end else if (func_q == oahs_pkg::FUNC_REMOVE) begin
			if (count_q == '0) begin
				res_status = oahs_pkg::ST_EMPTY_SET;
			end else if (found) begin
				res_status = oahs_pkg::ST_REMOVED;
				res_slot   = where;
				count_nx   = count_q - 1'b1;
				upd_en     = 1'b1;
				upd_mark   = oahs_pkg::MARK_TOMB;
			end else begin
				res_status = oahs_pkg::ST_NOT_FOUND;
			end
		end else begin
			// membership test, also the unused code
			if (found) begin
				res_status = oahs_pkg::ST_PRESENT;
				res_slot   = where;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= oahs_pkg::CS_CLEAR;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx  = state_q;
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = where;
		mem_wdata = '{mark: upd_mark, key: key_q};
		mem_raddr = idx_nx;
		unique case (state_q)
			oahs_pkg::CS_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '{mark: oahs_pkg::MARK_EMPTY, key: '0};
				if (clr_last)
					state_nx = oahs_pkg::CS_IDLE;
			end
			oahs_pkg::CS_IDLE: begin
				req.ready = 1'b1;
				if (req.valid)
					state_nx = oahs_pkg::CS_HASH;
			end
			oahs_pkg::CS_HASH: begin
				mem_raddr = hash_home;
				if (hash_done)
					state_nx = oahs_pkg::CS_PROBE;
			end
			oahs_pkg::CS_PROBE: begin
				// read ahead one slot; on a stalled finish keep reading the same slot
				if (finish)
					mem_raddr = idx_q;
				mem_we = commit && upd_en;
				if (commit)
					state_nx = oahs_pkg::CS_IDLE;
			end
			default: state_nx = oahs_pkg::CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == oahs_pkg::CS_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (commit) begin
				count_q     <= count_nx;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			key_q  <= req.key & KEY_MASK;
		end
		if (state_q == oahs_pkg::CS_HASH && hash_done) begin
			idx_q       <= hash_home;
			steps_q     <= '0;
			tomb_seen_q <= 1'b0;
		end else if (state_q == oahs_pkg::CS_PROBE && !finish) begin
			idx_q   <= idx_nx;
			steps_q <= steps_q + 1'b1;
			if (is_tomb && !tomb_seen_q) begin
				tomb_seen_q <= 1'b1;
				tomb_at_q   <= idx_q;
			end
		end
		if (commit) begin
			status_q <= res_status;
			slot_q   <= SLOT_W'(res_slot);
			total_q  <= TOTAL_W'(count_nx);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.slot_index    = slot_q;
	assign rsp.element_total = total_q;

endmodule

// File: src/open_addressing_hash_set_core.sv
// Channel   Dir  Payload                               Transaction when
// req       in   func[1:0], key[31:0]                  req.valid && req.ready
// rsp       out  status[2:0], slot_index[9:0],         rsp.valid && rsp.ready
//                element_total[10:0]
//
// After reset a clearing pass marks every slot empty, one slot per cycle;
// req.ready stays low until the pass is done.
// After acceptance an item is hashed, with a reduction to the slot range when
// SLOTS is not a power of two, and then probed; req.ready returns once its
// result is committed. The probe examines 1..SLOTS slots, and the slot memory
// read port sets one slot per cycle. The result register frees the input side:
// the next transaction is taken while a result waits; a probe that finishes
// while the previous result is still held waits for it to be taken.
//
// Top level: wires hash unit, slot memory and sequencer. Depends on oahs_pkg,
// oahs_if, oahs_hash, oahs_store and oahs_ctrl.
module open_addressing_hash_set_core #(
	parameter int SLOTS     = oahs_pkg::SLOTS_DEF,
	parameter int KEY_BYTES = oahs_pkg::KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	oahs_req_if.sink    req,
	oahs_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(SLOTS);

	logic                       hash_start;
	logic [oahs_pkg::KEY_W-1:0] hash_key;
	logic                       hash_done;
	logic [IDX_W-1:0]           hash_home;
	logic                       mem_we;
	logic [IDX_W-1:0]           mem_waddr;
	oahs_pkg::entry_t           mem_wdata;
	logic [IDX_W-1:0]           mem_raddr;
	oahs_pkg::entry_t           mem_rdata;

	oahs_hash #(
		.SLOTS     (SLOTS),
		.KEY_BYTES (KEY_BYTES)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (hash_key),
		.done   (hash_done),
		.home   (hash_home)
	);

	oahs_store #(
		.SLOTS (SLOTS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	oahs_ctrl #(
		.SLOTS     (SLOTS),
		.KEY_BYTES (KEY_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.hash_start (hash_start),
		.hash_key   (hash_key),
		.hash_done  (hash_done),
		.hash_home  (hash_home),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

endmodule

// File: sim/open_addressing_hash_set_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the open addressing hash set core: keeps its own slot table,
// predicts each response and compares it. Depends on oahs_pkg and oahs_if.
module open_addressing_hash_set_checker #(
	parameter int SLOTS     = oahs_pkg::SLOTS_DEF,
	parameter int KEY_BYTES = oahs_pkg::KEY_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	oahs_req_if  req,
	oahs_rsp_if  rsp,
	output int   mismatches,
	output int   pending,
	output int   stored
);
	import oahs_pkg::*;

	localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 4) ? 32'hFFFF_FFFF :
		32'((64'd1 << (8 * KEY_BYTES)) - 64'd1);

	typedef struct packed {
		status_t                 status;
		logic [SLOT_OUT_W-1:0]   slot;
		logic [TOTAL_OUT_W-1:0]  total;
	} outcome_t;

	mark_t            slot_state [SLOTS];
	logic [KEY_W-1:0] slot_val   [SLOTS];
	int unsigned      occupancy;
	outcome_t         due_results [$];
	outcome_t         want;
	int               miss_count;

	// FNV-1a over the key bytes, little-endian; bytes past the fourth hash as zero
	function automatic int unsigned home_slot(input logic [KEY_W-1:0] k);
		logic [31:0] h;
		h = 32'h811C_9DC5;
		for (int b = 0; b < KEY_BYTES; b++) begin
			h = h ^ ((b < 4) ? ((k >> (8 * b)) & 32'hFF) : 32'h0);
			h = h * 32'h0100_0193;
		end
		return h % SLOTS;
	endfunction

	// linear probe: stops at empty or matching slot; first tombstone is the
	// landing spot only when no empty slot turns up in a full lap
	function automatic void scan_slots(input logic [KEY_W-1:0] k, output bit hit,
			output bit room, output int unsigned spot);
		int unsigned home;
		int unsigned idx;
		int unsigned tomb_idx;
		bit          tomb_seen;
		home = home_slot(k);
		hit = 1'b0;
		room = 1'b0;
		spot = 0;
		tomb_seen = 1'b0;
		tomb_idx = 0;
		for (int unsigned n = 0; n < SLOTS; n++) begin
			idx = (home + n) % SLOTS;
			if (slot_state[idx] == MARK_EMPTY) begin
				room = 1'b1;
				spot = idx;
				return;
			end
			if (slot_state[idx] == MARK_FILLED) begin
				if (slot_val[idx] == k) begin
					hit = 1'b1;
					spot = idx;
					return;
				end
			end else if (!tomb_seen) begin
				tomb_seen = 1'b1;
				tomb_idx = idx;
			end
		end
		if (tomb_seen) begin
			room = 1'b1;
			spot = tomb_idx;
		end
	endfunction

	// applies one request to the table copy and returns its response
	function automatic outcome_t resolve_request(input logic [FUNC_W-1:0] f,
			input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] k;
		bit               hit;
		bit               room;
		int unsigned      spot;
		outcome_t         r;
		k = raw & KEY_MASK;
		r.slot = '0;
		if (f == FUNC_INSERT) begin
			scan_slots(k, hit, room, spot);
			if (hit) begin
				r.status = ST_PRESENT_INS;
				r.slot = SLOT_OUT_W'(spot);
			end else if (room) begin
				slot_state[spot] = MARK_FILLED;
				slot_val[spot] = k;
				occupancy++;
				r.status = ST_INSERTED;
				r.slot = SLOT_OUT_W'(spot);
			end else begin
				r.status = ST_FULL;
			end
		end else if (f == FUNC_REMOVE) begin
			if (occupancy == 0) begin
				r.status = ST_EMPTY_SET;
			end else begin
				scan_slots(k, hit, room, spot);
				if (hit) begin
					slot_state[spot] = MARK_TOMB;
					occupancy--;
					r.status = ST_REMOVED;
					r.slot = SLOT_OUT_W'(spot);
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
		end else begin
			// membership test; the spare code behaves the same
			scan_slots(k, hit, room, spot);
			if (hit) begin
				r.status = ST_PRESENT;
				r.slot = SLOT_OUT_W'(spot);
			end else begin
				r.status = ST_ABSENT;
			end
		end
		r.total = TOTAL_OUT_W'(occupancy);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) slot_state[s] = MARK_EMPTY;
			occupancy = 0;
			due_results.delete();
			miss_count = 0;
			mismatches <= 0;
			pending <= 0;
			stored <= 0;
		end else begin
			// response first: it always belongs to an earlier request transaction
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					if (miss_count < 10)
						$display("%0t: unexpected response status %0d slot %0d total %0d",
							$realtime, rsp.status, rsp.slot_index, rsp.element_total);
					miss_count++;
				end else begin
					want = due_results.pop_front();
					if (rsp.status !== want.status || rsp.slot_index !== want.slot ||
							rsp.element_total !== want.total) begin
						if (miss_count < 10)
							$display("%0t: exp %0d/%0d/%0d got %0d/%0d/%0d (status/slot/total)",
								$realtime, want.status, want.slot, want.total,
								rsp.status, rsp.slot_index, rsp.element_total);
						miss_count++;
					end
				end
			end
			if (req.valid && req.ready)
				due_results.push_back(resolve_request(req.func, req.key));
			mismatches <= miss_count;
			pending <= due_results.size();
			stored <= occupancy;
		end
	end

endmodule

// File: sim/open_addressing_hash_set_core_test.sv
`timescale 1ns / 1ps
// Testbench top for open_addressing_hash_set_core: clock, reset, request and
// response drivers, watchdog and verdict. Depends on oahs_pkg, oahs_if, checker.
module open_addressing_hash_set_core_test;
	import oahs_pkg::*;

	localparam int SLOTS          = 1024;
	localparam int KEY_BYTES      = 4;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 1100;

	localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	oahs_req_if req ();
	oahs_rsp_if rsp ();

	int mismatches;
	int pending;
	int stored;
	int req_calm = 0;
	int rsp_calm = 0;
	int quiet_cycles = 0;

	logic [KEY_W-1:0] pool_keys [$];
	logic [KEY_W-1:0] fill_keys [$];
	logic [KEY_W-1:0] gone_keys [$];

	always #5 clk = ~clk;

	open_addressing_hash_set_core #(
		.SLOTS     (SLOTS),
		.KEY_BYTES (KEY_BYTES)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	open_addressing_hash_set_checker #(
		.SLOTS     (SLOTS),
		.KEY_BYTES (KEY_BYTES)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending),
		.stored     (stored)
	);

	// mostly random gaps, with occasional back-to-back stretches
	function automatic int pick_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) calm = $urandom_range(16, 48);
		return $urandom_range(0, 9);
	endfunction

	function automatic logic [KEY_W-1:0] key_homed_at(input int unsigned home);
		logic [KEY_W-1:0] k;
		do k = $urandom(); while (u_check.home_slot(k) != home);
		return k;
	endfunction

	task automatic send_request(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
		int hold;
		hold = pick_gap(req_calm);
		if (hold != 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (hold - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.func  <= f;
		req.key   <= k;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : result_drain
		int hold;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = pick_gap(rsp_calm);
			if (hold != 0) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0] k;
		int               pick;
		int               idx;
		req.valid = 1'b0;
		req.func  = FUNC_INSERT;
		req.key   = '0;
		arst_n    = 1'b0;

		// colliding groups; the group homed at the last slot wraps into slot 0
		for (int n = 0; n < 6; n++) pool_keys.push_back(key_homed_at(SLOTS - 1));
		for (int n = 0; n < 4; n++) pool_keys.push_back(key_homed_at(0));
		for (int n = 0; n < 5; n++) pool_keys.push_back(key_homed_at(SLOTS / 2 - 1));
		for (int n = 0; n < 4; n++) pool_keys.push_back(key_homed_at(SLOTS / 2));
		pool_keys.push_back('0);
		pool_keys.push_back('1);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty set, key extremes, spare code, chain with a tombstone
		send_request(FUNC_REMOVE, '0);
		send_request(FUNC_TEST, '0);
		send_request(FUNC_SPARE, '1);
		send_request(FUNC_INSERT, '0);
		send_request(FUNC_INSERT, '1);
		send_request(FUNC_INSERT, '0);
		send_request(FUNC_TEST, '1);
		send_request(FUNC_SPARE, '0);
		send_request(FUNC_REMOVE, 32'h1234_5678);
		send_request(FUNC_INSERT, pool_keys[0]);
		send_request(FUNC_INSERT, pool_keys[1]);
		send_request(FUNC_INSERT, pool_keys[2]);
		send_request(FUNC_REMOVE, pool_keys[1]);
		send_request(FUNC_TEST, pool_keys[2]);
		send_request(FUNC_INSERT, pool_keys[1]);
		send_request(FUNC_TEST, pool_keys[1]);
		send_request(FUNC_REMOVE, pool_keys[0]);
		send_request(FUNC_REMOVE, pool_keys[2]);
		send_request(FUNC_REMOVE, pool_keys[1]);
		send_request(FUNC_REMOVE, '0);
		send_request(FUNC_REMOVE, '1);
		send_request(FUNC_REMOVE, pool_keys[0]);
		send_request(FUNC_INSERT, pool_keys[2]);
		wait_until_drained();

		// churn on a small colliding key pool
		repeat (180) begin
			pick = $urandom_range(0, 19);
			k = ($urandom_range(0, 6) == 0) ? $urandom() :
				pool_keys[$urandom_range(0, pool_keys.size() - 1)];
			if (pick < 8)
				send_request(FUNC_INSERT, k);
			else if (pick < 14)
				send_request(FUNC_REMOVE, k);
			else if (pick < 19)
				send_request(FUNC_TEST, k);
			else
				send_request(FUNC_SPARE, k);
		end
		wait_until_drained();

		// fill to capacity; the count seen here lags one transaction, so the
		// last insert already hits a full table
		while (stored < SLOTS) begin
			k = $urandom();
			fill_keys.push_back(k);
			send_request(FUNC_INSERT, k);
		end
		send_request(FUNC_INSERT, $urandom());
		send_request(FUNC_INSERT, fill_keys[0]);
		send_request(FUNC_TEST, $urandom());
		send_request(FUNC_REMOVE, $urandom());

		// no empty slots left: inserts must land on the first tombstone
		repeat (120) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				idx = $urandom_range(0, fill_keys.size() - 1);
				k = fill_keys[idx];
				fill_keys.delete(idx);
				gone_keys.push_back(k);
				send_request(FUNC_REMOVE, k);
			end else if (pick < 7) begin
				if (gone_keys.size() != 0 && $urandom_range(0, 1) == 0) begin
					idx = $urandom_range(0, gone_keys.size() - 1);
					k = gone_keys[idx];
					gone_keys.delete(idx);
				end else begin
					k = $urandom();
				end
				fill_keys.push_back(k);
				send_request(FUNC_INSERT, k);
			end else if (pick < 9) begin
				if (gone_keys.size() != 0 && $urandom_range(0, 1) == 0)
					k = gone_keys[$urandom_range(0, gone_keys.size() - 1)];
				else
					k = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
				send_request($urandom_range(0, 1) ? FUNC_TEST : FUNC_SPARE, k);
			end else begin
				send_request(FUNC_TEST, $urandom());
			end
		end

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
src/oahs_pkg.sv
src/oahs_if.sv
src/oahs_hash.sv
src/oahs_store.sv
src/oahs_ctrl.sv
src/open_addressing_hash_set_core.sv
sim/open_addressing_hash_set_checker.sv
sim/open_addressing_hash_set_core_test.sv
